[design/pwc_pkg.sv]
package pwc_pkg;

    localparam int ERROR_BITS_DEF = 16;
    localparam int GAIN_BITS      = 16;
    localparam int LIMIT_BITS     = 11;
    localparam int INTEG_BITS     = 12;
    localparam int WEIGHT_BITS    = 12;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_IDX_BITS   = 2;
    localparam int GAIN_SHIFT     = 12;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MIN  = 12'd256;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX  = 12'd2560;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_SPAN = WEIGHT_MAX - WEIGHT_MIN;

    localparam logic signed [GAIN_BITS-1:0] GAIN_P_RST    = 16'sd2048;
    localparam logic signed [GAIN_BITS-1:0] GAIN_I_RST    = 16'sd82;
    localparam logic signed [GAIN_BITS-1:0] GAIN_D_RST    = 16'sd205;
    localparam logic        [LIMIT_BITS-1:0] INT_LIMIT_RST = 11'd1280;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_INT_LIMIT
    } t_cfg_reg;

    typedef struct packed {
        logic restart;
        logic integ_clamp;
    } t_ctl;

endpackage

[design/pwc_integrator.sv]
module pwc_integrator import pwc_pkg::*; #(
    parameter int ERROR_BITS = ERROR_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic signed [ERROR_BITS-1:0] i_error_sample,
    input  logic                         i_restart,
    input  logic        [LIMIT_BITS-1:0] i_integral_limit,
    output logic signed [ERROR_BITS-1:0] o_error,
    output logic signed [INTEG_BITS-1:0] o_integral,
    output logic signed [ERROR_BITS:0]   o_deriv,
    output t_ctl                         o_ctl
);

    localparam int SW = ((ERROR_BITS > INTEG_BITS) ? ERROR_BITS : INTEG_BITS) + 1;

    logic signed [ERROR_BITS-1:0] r_prev;
    logic signed [INTEG_BITS-1:0] r_integral;
    logic signed [ERROR_BITS-1:0] r_error;
    logic signed [INTEG_BITS-1:0] r_integ_out;
    logic signed [ERROR_BITS:0]   r_deriv;
    t_ctl                         r_ctl;

    logic signed [SW-1:0]         w_sum;
    logic signed [SW-1:0]         w_lim;
    logic signed [SW-1:0]         w_clamped;
    logic                         w_clamp;
    logic signed [INTEG_BITS-1:0] n_integral;
    logic signed [ERROR_BITS:0]   w_deriv;
    t_ctl                         w_ctl;

    always_comb begin
        w_sum = SW'(i_error_sample) + SW'(r_integral);
        w_lim = $signed(SW'(i_integral_limit));
        if (w_sum > w_lim) begin
            w_clamped = w_lim;
            w_clamp   = 1'b1;
        end else if (w_sum < -w_lim) begin
            w_clamped = -w_lim;
            w_clamp   = 1'b1;
        end else begin
            w_clamped = w_sum;
            w_clamp   = 1'b0;
        end
        w_deriv = (ERROR_BITS+1)'(i_error_sample) - (ERROR_BITS+1)'(r_prev);
        if (i_restart) begin
            n_integral      = '0;
            w_ctl.restart     = 1'b1;
            w_ctl.integ_clamp = 1'b0;
        end else begin
            n_integral        = w_clamped[INTEG_BITS-1:0];
            w_ctl.restart     = 1'b0;
            w_ctl.integ_clamp = w_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_integral <= '0;
        end else if (i_load) begin
            r_prev     <= i_error_sample;
            r_integral <= n_integral;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_error     <= i_error_sample;
            r_integ_out <= n_integral;
            r_deriv     <= w_deriv;
            r_ctl       <= w_ctl;
        end
    end

    assign o_error    = r_error;
    assign o_integral = r_integ_out;
    assign o_deriv    = r_deriv;
    assign o_ctl      = r_ctl;

endmodule

[design/pwc_product.sv]
module pwc_product import pwc_pkg::*; #(
    parameter int ERROR_BITS = ERROR_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  logic signed [ERROR_BITS-1:0]          i_error,
    input  logic signed [INTEG_BITS-1:0]          i_integral,
    input  logic signed [ERROR_BITS:0]            i_deriv,
    input  t_ctl                                  i_ctl,
    input  logic signed [GAIN_BITS-1:0]           i_gain_p,
    input  logic signed [GAIN_BITS-1:0]           i_gain_i,
    input  logic signed [GAIN_BITS-1:0]           i_gain_d,
    output logic signed [GAIN_BITS+ERROR_BITS-1:0] o_prod_p,
    output logic signed [GAIN_BITS+INTEG_BITS-1:0] o_prod_i,
    output logic signed [GAIN_BITS+ERROR_BITS:0]   o_prod_d,
    output t_ctl                                  o_ctl
);

    logic signed [GAIN_BITS+ERROR_BITS-1:0] r_prod_p;
    logic signed [GAIN_BITS+INTEG_BITS-1:0] r_prod_i;
    logic signed [GAIN_BITS+ERROR_BITS:0]   r_prod_d;
    t_ctl                                   r_ctl;

    logic signed [GAIN_BITS+ERROR_BITS-1:0] n_prod_p;
    logic signed [GAIN_BITS+INTEG_BITS-1:0] n_prod_i;
    logic signed [GAIN_BITS+ERROR_BITS:0]   n_prod_d;

    always_comb begin
        n_prod_p = i_gain_p * i_error;
        n_prod_i = i_gain_i * i_integral;
        n_prod_d = i_gain_d * i_deriv;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
            r_ctl    <= i_ctl;
        end
    end

    assign o_prod_p = r_prod_p;
    assign o_prod_i = r_prod_i;
    assign o_prod_d = r_prod_d;
    assign o_ctl    = r_ctl;

endmodule

[design/pwc_weight.sv]
module pwc_weight import pwc_pkg::*; #(
    parameter int ERROR_BITS = ERROR_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  logic signed [GAIN_BITS+ERROR_BITS-1:0] i_prod_p,
    input  logic signed [GAIN_BITS+INTEG_BITS-1:0] i_prod_i,
    input  logic signed [GAIN_BITS+ERROR_BITS:0]   i_prod_d,
    input  t_ctl                                   i_ctl,
    output logic        [WEIGHT_BITS-1:0]          o_weight,
    output logic                                   o_integral_clamped,
    output logic                                   o_weight_clamped
);

    localparam int AW = GAIN_BITS + 2
                      + ((ERROR_BITS + 1 > INTEG_BITS) ? ERROR_BITS + 1 : INTEG_BITS);
    localparam int SW = AW - GAIN_SHIFT;

    logic [WEIGHT_BITS-1:0] r_weight;
    logic                   r_iclamp;
    logic                   r_wclamp;

    logic signed [AW-1:0]   w_acc;
    logic signed [SW-1:0]   w_shifted;
    logic [WEIGHT_BITS-1:0] n_weight;
    logic                   n_iclamp;
    logic                   n_wclamp;

    always_comb begin
        w_acc     = AW'(i_prod_p) + AW'(i_prod_i) + AW'(i_prod_d);
        // floor shift from q15.20 to q15.8
        w_shifted = w_acc[AW-1:GAIN_SHIFT];
        if (i_ctl.restart) begin
            n_weight = WEIGHT_MIN;
            n_iclamp = 1'b0;
            n_wclamp = 1'b0;
        end else begin
            n_iclamp = i_ctl.integ_clamp;
            if (w_shifted < 0) begin
                n_weight = WEIGHT_MIN;
                n_wclamp = 1'b1;
            end else if (w_shifted > $signed(SW'(WEIGHT_SPAN))) begin
                n_weight = WEIGHT_MAX;
                n_wclamp = 1'b1;
            end else begin
                n_weight = WEIGHT_MIN + w_shifted[WEIGHT_BITS-1:0];
                n_wclamp = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_weight <= n_weight;
            r_iclamp <= n_iclamp;
            r_wclamp <= n_wclamp;
        end
    end

    assign o_weight           = r_weight;
    assign o_integral_clamped = r_iclamp;
    assign o_weight_clamped   = r_wclamp;

endmodule

[design/pid_weight_controller.sv]
// throughput: one transaction per cycle while i_stall is low, limited by the integrator add and clamp
// pipeline: input register, integrator, multipliers, sum with weight clamp and output register
// reset: synchronous active low; clears pipeline valids, previous error and integral,
// and loads the default gains and integral limit
module pid_weight_controller import pwc_pkg::*; #(
    parameter int ERROR_BITS = ERROR_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [ERROR_BITS-1:0] i_error_sample,
    input  logic                         i_restart,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic        [WEIGHT_BITS-1:0] o_weight,
    output logic                         o_integral_clamped,
    output logic                         o_weight_clamped,
    input  logic                         i_cfg_wr_en,
    input  logic     [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic     [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic signed [GAIN_BITS-1:0]  r_gain_p;
    logic signed [GAIN_BITS-1:0]  r_gain_i;
    logic signed [GAIN_BITS-1:0]  r_gain_d;
    logic        [LIMIT_BITS-1:0] r_int_limit;

    logic                         r_v0;
    logic                         r_v1;
    logic                         r_v2;
    logic                         r_v3;
    logic signed [ERROR_BITS-1:0] r_error;
    logic                         r_restart;

    logic w_rdy0;
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;

    logic signed [ERROR_BITS-1:0]           s1_error;
    logic signed [INTEG_BITS-1:0]           s1_integral;
    logic signed [ERROR_BITS:0]             s1_deriv;
    t_ctl                                   s1_ctl;
    logic signed [GAIN_BITS+ERROR_BITS-1:0] s2_prod_p;
    logic signed [GAIN_BITS+INTEG_BITS-1:0] s2_prod_i;
    logic signed [GAIN_BITS+ERROR_BITS:0]   s2_prod_d;
    t_ctl                                   s2_ctl;

    assign w_rdy3  = !r_v3 || !i_stall;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign w_rdy0  = !r_v0 || w_rdy1;
    assign o_stall = !w_rdy0;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= GAIN_P_RST;
            r_gain_i    <= GAIN_I_RST;
            r_gain_d    <= GAIN_D_RST;
            r_int_limit <= INT_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_GAIN_P:    r_gain_p    <= i_cfg_data;
                REG_GAIN_I:    r_gain_i    <= i_cfg_data;
                REG_GAIN_D:    r_gain_d    <= i_cfg_data;
                REG_INT_LIMIT: r_int_limit <= i_cfg_data[LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy0) begin
            r_error   <= i_error_sample;
            r_restart <= i_restart;
        end
    end

    pwc_integrator #(
        .ERROR_BITS(ERROR_BITS)
    ) u_integrator (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (r_v0 && w_rdy1),
        .i_error_sample   (r_error),
        .i_restart        (r_restart),
        .i_integral_limit (r_int_limit),
        .o_error          (s1_error),
        .o_integral       (s1_integral),
        .o_deriv          (s1_deriv),
        .o_ctl            (s1_ctl)
    );

    pwc_product #(
        .ERROR_BITS(ERROR_BITS)
    ) u_product (
        .i_clk      (i_clk),
        .i_load     (r_v1 && w_rdy2),
        .i_error    (s1_error),
        .i_integral (s1_integral),
        .i_deriv    (s1_deriv),
        .i_ctl      (s1_ctl),
        .i_gain_p   (r_gain_p),
        .i_gain_i   (r_gain_i),
        .i_gain_d   (r_gain_d),
        .o_prod_p   (s2_prod_p),
        .o_prod_i   (s2_prod_i),
        .o_prod_d   (s2_prod_d),
        .o_ctl      (s2_ctl)
    );

    pwc_weight #(
        .ERROR_BITS(ERROR_BITS)
    ) u_weight (
        .i_clk              (i_clk),
        .i_load             (r_v2 && w_rdy3),
        .i_prod_p           (s2_prod_p),
        .i_prod_i           (s2_prod_i),
        .i_prod_d           (s2_prod_d),
        .i_ctl              (s2_ctl),
        .o_weight           (o_weight),
        .o_integral_clamped (o_integral_clamped),
        .o_weight_clamped   (o_weight_clamped)
    );

endmodule

[design/pwc_checker.sv]
module pwc_checker import pwc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_stall,
    input logic [WEIGHT_BITS-1:0] i_weight,
    input logic                   i_weight_clamped
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_weight >= WEIGHT_MIN) && (i_weight <= WEIGHT_MAX))
        else $error("weight outside 1.0 .. 10.0");

    a_clamp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_weight_clamped |-> (i_weight == WEIGHT_MIN) || (i_weight == WEIGHT_MAX))
        else $error("clamped weight not on a bound");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_weight))
        else $error("stalled result changed");

endmodule

bind pid_weight_controller pwc_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_valid),
    .i_out_stall      (i_stall),
    .i_weight         (o_weight),
    .i_weight_clamped (o_weight_clamped)
);

[verif/tb.sv]
module tb;
    import pwc_pkg::*;

    localparam int PIPE_LAT = 4;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int N_ROWS = 29;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic                   integ_clamp;
        logic                   weight_clamp;
    } t_weight_res;

    typedef struct packed {
        logic        is_cfg;
        t_cfg_reg    reg_sel;
        logic [15:0] value;
        logic        rs;
        logic        typed;
        t_weight_res want;
    } t_dir_row;

    // value is the error sample for a transaction, or the register data for a write
    localparam t_dir_row DIR_ROWS [0:N_ROWS-1] = '{
        '{1'b0, REG_GAIN_P,    16'h0000, 1'b1, 1'b1, '{12'd256,  1'b0, 1'b0}},
        '{1'b0, REG_GAIN_P,    16'h8000, 1'b1, 1'b1, '{12'd256,  1'b0, 1'b0}},
        '{1'b0, REG_GAIN_P,    16'h7FFF, 1'b0, 1'b1, '{12'd2560, 1'b1, 1'b1}},
        '{1'b0, REG_GAIN_P,    16'h8000, 1'b0, 1'b1, '{12'd256,  1'b1, 1'b1}},
        '{1'b0, REG_GAIN_P,    16'h0000, 1'b1, 1'b1, '{12'd256,  1'b0, 1'b0}},
        '{1'b0, REG_GAIN_P,    16'h0000, 1'b0, 1'b1, '{12'd256,  1'b0, 1'b0}},
        '{1'b0, REG_GAIN_P,    16'h0500, 1'b0, 1'b0, '0},
        '{1'b0, REG_GAIN_P,    16'h0001, 1'b0, 1'b0, '0},
        '{1'b0, REG_GAIN_P,    16'hF600, 1'b0, 1'b0, '0},
        '{1'b0, REG_GAIN_P,    16'hFFFF, 1'b0, 1'b0, '0},
        '{1'b1, REG_GAIN_P,    16'h1000, 1'b0, 1'b0, '0},
        '{1'b1, REG_GAIN_I,    16'h0000, 1'b0, 1'b0, '0},
        '{1'b1, REG_GAIN_D,    16'h0000, 1'b0, 1'b0, '0},
        '{1'b1, REG_INT_LIMIT, 16'h0000, 1'b0, 1'b0, '0},
        '{1'b0, REG_GAIN_P,    16'h0900, 1'b0, 1'b1, '{12'd2560, 1'b1, 1'b0}},
        '{1'b0, REG_GAIN_P,    16'h0901, 1'b0, 1'b1, '{12'd2560, 1'b1, 1'b1}},
        '{1'b0, REG_GAIN_P,    16'h0000, 1'b0, 1'b1, '{12'd256,  1'b0, 1'b0}},
        '{1'b0, REG_GAIN_P,    16'hFFFF, 1'b0, 1'b1, '{12'd256,  1'b1, 1'b1}},
        '{1'b1, REG_GAIN_P,    16'h0001, 1'b0, 1'b0, '0},
        '{1'b0, REG_GAIN_P,    16'hFFFF, 1'b0, 1'b1, '{12'd256,  1'b1, 1'b1}},
        '{1'b0, REG_GAIN_P,    16'h0001, 1'b0, 1'b1, '{12'd256,  1'b1, 1'b0}},
        '{1'b1, REG_GAIN_P,    16'h8000, 1'b0, 1'b0, '0},
        '{1'b1, REG_GAIN_I,    16'h7FFF, 1'b0, 1'b0, '0},
        '{1'b1, REG_GAIN_D,    16'h8000, 1'b0, 1'b0, '0},
        '{1'b1, REG_INT_LIMIT, 16'hFFFF, 1'b0, 1'b0, '0},
        '{1'b0, REG_GAIN_P,    16'h03E8, 1'b0, 1'b0, '0},
        '{1'b0, REG_GAIN_P,    16'hFC18, 1'b0, 1'b0, '0},
        '{1'b0, REG_GAIN_P,    16'h007B, 1'b1, 1'b1, '{12'd256,  1'b0, 1'b0}},
        '{1'b0, REG_GAIN_P,    16'h0040, 1'b0, 1'b0, '0}
    };

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_stall;
    logic signed [ERROR_BITS_DEF-1:0] i_error_sample = '0;
    logic                             i_restart = 1'b0;
    logic                             o_valid;
    logic                             i_stall = 1'b0;
    logic        [WEIGHT_BITS-1:0]    o_weight;
    logic                             o_integral_clamped;
    logic                             o_weight_clamped;
    logic                             i_cfg_wr_en = 1'b0;
    logic        [CFG_IDX_BITS-1:0]   i_cfg_index = '0;
    logic        [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    logic        src_gaps = 1'b1;
    logic        sink_gaps = 1'b1;
    logic        row_typed = 1'b0;
    t_weight_res row_want = '0;

    logic signed [GAIN_BITS-1:0]      gain_p_q, gain_i_q, gain_d_q;
    logic        [LIMIT_BITS-1:0]     limit_q;
    logic signed [ERROR_BITS_DEF-1:0] prev_err_q;
    logic signed [INTEG_BITS-1:0]     integ_q;

    t_weight_res weight_q [$];
    int          n_mismatch = 0;

    pid_weight_controller dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_error_sample     (i_error_sample),
        .i_restart          (i_restart),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_weight           (o_weight),
        .o_integral_clamped (o_integral_clamped),
        .o_weight_clamped   (o_weight_clamped),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** pid_weight_controller: FAILED **");
        $finish;
    end

    function automatic t_weight_res next_weight(input logic signed [ERROR_BITS_DEF-1:0] e,
                                                input logic rs);
        t_weight_res r;
        longint      deriv, sum, lim, acc, w;
        r = '0;
        if (rs) begin
            integ_q = '0;
            prev_err_q = e;
            r.weight = WEIGHT_MIN;
            return r;
        end
        lim = longint'(limit_q);
        deriv = longint'(e) - longint'(prev_err_q);
        sum = longint'(integ_q) + longint'(e);
        if (sum > lim) begin
            sum = lim;
            r.integ_clamp = 1'b1;
        end
        if (sum < -lim) begin
            sum = -lim;
            r.integ_clamp = 1'b1;
        end
        acc = longint'(gain_p_q) * longint'(e) + longint'(gain_i_q) * sum
            + longint'(gain_d_q) * deriv;
        w = longint'(WEIGHT_MIN) + (acc >>> GAIN_SHIFT);
        if (w < longint'(WEIGHT_MIN)) begin
            w = longint'(WEIGHT_MIN);
            r.weight_clamp = 1'b1;
        end
        if (w > longint'(WEIGHT_MAX)) begin
            w = longint'(WEIGHT_MAX);
            r.weight_clamp = 1'b1;
        end
        integ_q = sum[INTEG_BITS-1:0];
        prev_err_q = e;
        r.weight = w[WEIGHT_BITS-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_weight_res r;
        if (!i_rst_n) begin
            gain_p_q = GAIN_P_RST;
            gain_i_q = GAIN_I_RST;
            gain_d_q = GAIN_D_RST;
            limit_q = INT_LIMIT_RST;
            prev_err_q = '0;
            integ_q = '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_GAIN_P:    gain_p_q = i_cfg_data;
                    REG_GAIN_I:    gain_i_q = i_cfg_data;
                    REG_GAIN_D:    gain_d_q = i_cfg_data;
                    REG_INT_LIMIT: limit_q = i_cfg_data[LIMIT_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                r = next_weight(i_error_sample, i_restart);
                if (row_typed)
                    r = row_want;
                weight_q.push_back(r);
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        n_mismatch++;
        // keep the log short when something is badly broken
        if (n_mismatch <= 100)
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    always @(posedge i_clk) begin
        t_weight_res w;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (weight_q.size() == 0) begin
                report_mismatch("unexpected transaction, weight", o_weight, 0);
            end else begin
                w = weight_q.pop_front();
                if (o_weight !== w.weight)
                    report_mismatch("weight", o_weight, w.weight);
                if (o_integral_clamped !== w.integ_clamp)
                    report_mismatch("integral_clamped", o_integral_clamped, w.integ_clamp);
                if (o_weight_clamped !== w.weight_clamp)
                    report_mismatch("weight_clamped", o_weight_clamped, w.weight_clamp);
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= sink_gaps && ($urandom_range(99) < 35);
    end

    task automatic wait_drained();
        while (weight_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_sample(input logic [15:0] e, input logic rs, input logic typed,
                               input t_weight_res want);
        while (src_gaps && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_error_sample <= e;
        i_restart <= rs;
        row_typed <= typed;
        row_want <= want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg sel, input logic [15:0] value);
        i_valid <= 1'b0;
        wait_drained();
        repeat (PIPE_LAT + 2) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_gain(input int phase);
        if (phase == 1)
            return 16'h7FFF;
        if (phase == 2)
            return 16'h8000;
        case ($urandom_range(5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 8192) - 4096);
        endcase
    endfunction

    function automatic logic [15:0] pick_limit(input int phase);
        if (phase == 1)
            return 16'h07FF;
        if (phase == 2)
            return 16'h0000;
        case ($urandom_range(4))
            0:       return 16'h0000;
            1:       return 16'h07FF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic logic [15:0] pick_error();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 16'($urandom_range(0, 1200) - 600);
        if (r < 75)
            return 16'($urandom_range(0, 6000) - 3000);
        if (r < 95)
            return 16'($urandom);
        case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    initial begin
        t_dir_row row;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_ROWS; k++) begin
            row = DIR_ROWS[k];
            if (row.is_cfg)
                write_reg(row.reg_sel, row.value);
            else
                send_sample(row.value, row.rs, row.typed, row.want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0) begin
                write_reg(REG_GAIN_P, GAIN_P_RST);
                write_reg(REG_GAIN_I, GAIN_I_RST);
                write_reg(REG_GAIN_D, GAIN_D_RST);
                write_reg(REG_INT_LIMIT, 16'(INT_LIMIT_RST));
            end else begin
                write_reg(REG_GAIN_P, pick_gain(p));
                write_reg(REG_GAIN_I, pick_gain(p));
                write_reg(REG_GAIN_D, pick_gain(p));
                write_reg(REG_INT_LIMIT, pick_limit(p));
            end
            // one phase runs at full rate on both sides
            src_gaps <= (p != 3);
            sink_gaps <= (p != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(199) == 0) begin
                    i_valid <= 1'b0;
                    wait_drained();
                    @(negedge i_clk);
                end
                send_sample(pick_error(), $urandom_range(99) < 4, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        wait_drained();
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("** pid_weight_controller: PASSED **");
        else
            $display("** pid_weight_controller: FAILED **");
        $finish;
    end

endmodule
